>>> rtl/core/pfd_pkg.sv
package pfd_pkg;

  localparam int unsigned COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PAYLOAD_LEN = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_WINDOW      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CODE_DATA       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CODE_ACK        = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CODE_NACK       = 3'd4;

  localparam logic [15:0] RST_MAX_PAYLOAD_LEN = 16'd512;
  localparam logic [4:0]  RST_MAX_WINDOW      = 5'd31;
  localparam logic [2:0]  RST_CODE_DATA       = 3'd1;
  localparam logic [2:0]  RST_CODE_ACK        = 3'd2;
  localparam logic [2:0]  RST_CODE_NACK       = 3'd3;

  localparam logic ITEM_PAYLOAD = 1'b0;
  localparam logic ITEM_STATUS  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_HEADER  = 3'd1,
    ST_BAD_TYPE   = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_BAD_WINDOW = 3'd4,
    ST_BAD_CRC    = 3'd5,
    ST_NO_PAYLOAD = 3'd6
  } status_t;

  // one queue slot: an optional payload word followed by an optional status word
  typedef struct packed {
    logic        has_pay;
    logic [7:0]  pay;
    logic        has_stat;
    status_t     status;
    logic [2:0]  ty;
    logic [4:0]  win;
    logic [7:0]  seq;
    logic [15:0] len;
  } pfd_entry_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/pfd_if.sv
interface pfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source (output valid, output data_byte, output end_of_frame, input ready);
  modport sink (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface pfd_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [2:0]  pkt_type;
  logic [4:0]  window_field;
  logic [7:0]  seq_number;
  logic [15:0] header_length;
  logic        run_last;

  modport source (output valid, output item_kind, output payload_byte, output status,
                  output pkt_type, output window_field, output seq_number,
                  output header_length, output run_last, input ready);
  modport sink (input valid, input item_kind, input payload_byte, input status,
                input pkt_type, input window_field, input seq_number,
                input header_length, input run_last, output ready);
endinterface

interface pfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [15:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

>>> rtl/core/packet_frame_decoder_crc32.sv
// result words are registered in a queue slot and shown from the queue head
// throughput: one byte per cycle; a final byte that also frees a payload byte yields
// two words, sent one after the other from the same queue slot
// the front stalls only when the result queue (QUEUE_DEPTH slots) is full
// reset: synchronous rst clears the frame state and the queue, and returns the
// limits and type codes to their defaults
module packet_frame_decoder_crc32 #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  pfd_in_if.sink    frame,
  pfd_out_if.source result,
  pfd_cfg_if.sink   cfg
);
  import pfd_pkg::*;

  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  pfd_entry_t q_entry;
  pfd_entry_t q_head;

  pfd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  pfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  pfd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .empty  (q_empty),
    .pop    (q_pop),
    .result (result)
  );

endmodule

>>> rtl/core/pfd_front.sv
module pfd_front (
  input  logic                clk,
  input  logic                rst,
  pfd_in_if.sink              frame,
  pfd_cfg_if.sink             cfg,
  input  logic                q_full,
  output logic                q_push,
  output pfd_pkg::pfd_entry_t q_entry
);
  import pfd_pkg::*;

  logic [15:0] max_payload_len;
  logic [4:0]  max_window;
  logic [2:0]  code_data;
  logic [2:0]  code_ack;
  logic [2:0]  code_nack;

  logic [7:0]         tail_bytes [4];
  logic [COUNT_W-1:0] byte_count;
  logic [31:0]        crc_accum;
  logic [7:0]         first_header_byte;
  logic [7:0]         seq_reg;
  logic [15:0]        length_reg;

  logic               accept;
  logic [COUNT_W-1:0] count_next;
  logic [31:0]        crc_next;
  logic [7:0]         fhb_next;
  logic [7:0]         seq_next;
  logic [15:0]        length_next;
  logic               have_pay;
  logic [2:0]         ty;
  logic [4:0]         win;
  logic [31:0]        rx_crc;
  status_t            st;

  assign cfg.ready   = 1'b1;
  assign frame.ready = !q_full;
  assign accept      = frame.valid && frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= RST_MAX_PAYLOAD_LEN;
      max_window      <= RST_MAX_WINDOW;
      code_data       <= RST_CODE_DATA;
      code_ack        <= RST_CODE_ACK;
      code_nack       <= RST_CODE_NACK;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_MAX_PAYLOAD_LEN: max_payload_len <= cfg.data;
        REG_MAX_WINDOW:      max_window      <= cfg.data[4:0];
        REG_CODE_DATA:       code_data       <= cfg.data[2:0];
        REG_CODE_ACK:        code_ack        <= cfg.data[2:0];
        REG_CODE_NACK:       code_nack       <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  // header capture, byte count, payload flag, crc over the byte leaving the delay line
  always_comb begin
    fhb_next    = (byte_count == COUNT_W'(0)) ? frame.data_byte : first_header_byte;
    seq_next    = (byte_count == COUNT_W'(1)) ? frame.data_byte : seq_reg;
    length_next = length_reg;
    if (byte_count == COUNT_W'(2)) length_next = {frame.data_byte, length_reg[7:0]};
    if (byte_count == COUNT_W'(3)) length_next = {length_reg[15:8], frame.data_byte};
    crc_next   = (byte_count >= COUNT_W'(4)) ? crc32_byte(crc_accum, tail_bytes[0]) : crc_accum;
    have_pay   = (byte_count >= COUNT_W'(8)) &&
                 ({1'b0, byte_count} < ({2'b00, length_reg} + 18'd8));
    count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + COUNT_W'(1);
  end

  always_comb begin
    ty     = fhb_next[7:5];
    win    = fhb_next[4:0];
    rx_crc = {tail_bytes[1], tail_bytes[2], tail_bytes[3], frame.data_byte};
    if (count_next < COUNT_W'(4)) begin
      st = ST_NO_HEADER;
    end else if (ty != code_data && ty != code_ack && ty != code_nack) begin
      st = ST_BAD_TYPE;
    end else if (length_next > max_payload_len) begin
      st = ST_BAD_LENGTH;
    end else if (win > max_window) begin
      st = ST_BAD_WINDOW;
    end else if (~crc_next != rx_crc) begin
      st = ST_BAD_CRC;
    end else if (ty != code_data) begin
      st = (count_next == COUNT_W'(8)) ? ST_OK : ST_BAD_LENGTH;
    end else if (length_next == 16'd0) begin
      st = ST_NO_PAYLOAD;
    end else if ({1'b0, count_next} < ({2'b00, length_next} + 18'd8)) begin
      st = (count_next == COUNT_W'(8)) ? ST_NO_PAYLOAD : ST_BAD_LENGTH;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    q_push           = accept && (have_pay || frame.end_of_frame);
    q_entry.has_pay  = have_pay;
    q_entry.pay      = tail_bytes[0];
    q_entry.has_stat = frame.end_of_frame;
    q_entry.status   = st;
    if (st == ST_NO_HEADER) begin
      q_entry.ty  = '0;
      q_entry.win = '0;
      q_entry.seq = '0;
      q_entry.len = '0;
    end else begin
      q_entry.ty  = ty;
      q_entry.win = win;
      q_entry.seq = seq_next;
      q_entry.len = length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) tail_bytes[i] <= '0;
      byte_count        <= '0;
      crc_accum         <= CRC_INIT;
      first_header_byte <= '0;
      seq_reg           <= '0;
      length_reg        <= '0;
    end else if (accept) begin
      if (frame.end_of_frame) begin
        for (int i = 0; i < 4; i++) tail_bytes[i] <= '0;
        byte_count        <= '0;
        crc_accum         <= CRC_INIT;
        first_header_byte <= '0;
        seq_reg           <= '0;
        length_reg        <= '0;
      end else begin
        tail_bytes[0]     <= tail_bytes[1];
        tail_bytes[1]     <= tail_bytes[2];
        tail_bytes[2]     <= tail_bytes[3];
        tail_bytes[3]     <= frame.data_byte;
        byte_count        <= count_next;
        crc_accum         <= crc_next;
        first_header_byte <= fhb_next;
        seq_reg           <= seq_next;
        length_reg        <= length_next;
      end
    end
  end

  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && frame.end_of_frame) |=> (byte_count == '0 && crc_accum == CRC_INIT))
    else $error("frame state not cleared after end of frame");

  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("push into full queue");

endmodule

>>> rtl/core/pfd_queue.sv
module pfd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pfd_pkg::pfd_entry_t push_entry,
  input  logic                pop,
  output pfd_pkg::pfd_entry_t head,
  output logic                full,
  output logic                empty
);
  import pfd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pfd_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> rtl/core/pfd_back.sv
module pfd_back (
  input  logic                clk,
  input  logic                rst,
  input  pfd_pkg::pfd_entry_t head,
  input  logic                empty,
  output logic                pop,
  pfd_out_if.source           result
);
  import pfd_pkg::*;

  logic pay_done;
  logic emit_pay;
  logic take;

  assign emit_pay = head.has_pay && !pay_done;
  assign take     = result.valid && result.ready;
  // a slot leaves once its final word has gone
  assign pop      = take && !(emit_pay && head.has_stat);

  always_comb begin
    result.valid = !empty;
    if (emit_pay) begin
      result.item_kind     = ITEM_PAYLOAD;
      result.payload_byte  = head.pay;
      result.status        = '0;
      result.pkt_type      = '0;
      result.window_field  = '0;
      result.seq_number    = '0;
      result.header_length = '0;
      result.run_last      = !head.has_stat;
    end else begin
      result.item_kind     = ITEM_STATUS;
      result.payload_byte  = '0;
      result.status        = head.status;
      result.pkt_type      = head.ty;
      result.window_field  = head.win;
      result.seq_number    = head.seq;
      result.header_length = head.len;
      result.run_last      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pay_done <= 1'b0;
    end else if (take) begin
      pay_done <= emit_pay && head.has_stat;
    end
  end

  a_split_slot: assert property (@(posedge clk) disable iff (rst)
    pay_done |-> (!empty && head.has_pay && head.has_stat))
    else $error("second half of a slot without a pending status word");

endmodule
